// ===== hdl/crm_pkg.sv =====
package crm_pkg;

    // table geometry
    localparam int NCPU   = 64;
    localparam int IDX_W  = (NCPU > 1) ? $clog2(NCPU) : 1;
    localparam int ENT_W  = 6;
    localparam int MASK_W = 64;
    localparam int CNT_W  = $clog2(MASK_W);
    localparam int CPU_W  = 7;
    localparam int SCPU_W = 8;

    localparam logic [CPU_W-1:0] NCPU_V   = CPU_W'(NCPU);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MASK_W - 1);

    // word kinds on the input channel
    typedef enum logic [1:0] {
        KIND_LOAD = 2'd0,
        KIND_FWD  = 2'd1,
        KIND_REV  = 2'd2,
        KIND_ONE  = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_LOOK,
        ST_HOLD
    } state_t;

    // one table port: write and registered read
    typedef struct packed {
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        logic [ENT_W-1:0] wr_data;
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
    } tbl_req_t;

endpackage

// ===== hdl/cpu_set_remap_engine_unit.sv =====
// Load words go to ST_HOLD at accept, single-cpu words via ST_LOOK; ST_HOLD moves the result
// to the output register once it is free. Mask remap words: one mask bit per cycle through
// the table read port in ST_SCAN, then ST_DRAIN and ST_HOLD; a new word is taken only in ST_IDLE.
// Output register lets the next word start while a result waits to be taken.
// Reset (aresetn low, synchronous) returns both tables to identity at once.
module cpu_set_remap_engine_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [87:0] s_tdata,   // from_cpu[6:0], to_cpu[13:7], mask_in[77:14],
                                   // single_cpu[85:78], zero pad
    input  logic [1:0]  s_tuser,   // kind[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata    // mask_out[63:0], cpu_out[71:64], load_error[72],
                                   // zero pad
);

    crm_pkg::kind_t                  in_kind;
    logic [crm_pkg::CPU_W-1:0]       in_from;
    logic [crm_pkg::CPU_W-1:0]       in_to;
    logic [crm_pkg::MASK_W-1:0]      in_mask;
    logic [crm_pkg::SCPU_W-1:0]      in_single;

    crm_pkg::state_t                 state_reg, state_next;
    crm_pkg::kind_t                  kind_reg;
    logic [crm_pkg::MASK_W-1:0]      mask_sr_reg;
    logic [crm_pkg::CNT_W-1:0]       cnt_reg;
    logic [crm_pkg::SCPU_W-1:0]      raw_reg;
    logic                            in_range_reg;
    logic                            pend_reg, pend_next;
    logic                            pass_reg;
    logic [crm_pkg::CNT_W-1:0]       pidx_reg;
    logic [crm_pkg::MASK_W-1:0]      res_mask_reg;
    logic [crm_pkg::SCPU_W-1:0]      res_cpu_reg;
    logic                            res_err_reg;
    logic                            m_valid_reg, m_valid_next;
    logic [crm_pkg::MASK_W-1:0]      m_mask_reg;
    logic [crm_pkg::SCPU_W-1:0]      m_cpu_reg;
    logic                            m_err_reg;

    logic                            accept;
    logic                            scan_en;
    logic                            look_en;
    logic                            out_free;
    logic                            out_load;
    logic                            load_ok;
    logic                            single_ok;
    logic                            scan_in_range;
    logic [crm_pkg::ENT_W-1:0]       fwd_data;
    logic [crm_pkg::ENT_W-1:0]       rev_data;
    logic [crm_pkg::ENT_W-1:0]       tab_val;
    logic [crm_pkg::CNT_W-1:0]       bit_pos;
    logic [crm_pkg::MASK_W-1:0]      bit_dec;
    crm_pkg::tbl_req_t               fwd_req;
    crm_pkg::tbl_req_t               rev_req;

    // input word fields
    assign in_kind   = crm_pkg::kind_t'(s_tuser);
    assign in_from   = s_tdata[6:0];
    assign in_to     = s_tdata[13:7];
    assign in_mask   = s_tdata[77:14];
    assign in_single = s_tdata[85:78];

    assign accept    = s_tvalid && s_tready;
    assign out_free  = !m_valid_reg || m_tready;

    assign load_ok   = (in_from < crm_pkg::NCPU_V) && (in_to < crm_pkg::NCPU_V);
    assign single_ok = !in_single[crm_pkg::SCPU_W-1]
                       && (in_single[crm_pkg::CPU_W-1:0] < crm_pkg::NCPU_V);
    assign scan_in_range = crm_pkg::CPU_W'(cnt_reg) < crm_pkg::NCPU_V;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            crm_pkg::ST_IDLE: begin
                if (accept) begin
                    unique case (in_kind)
                        crm_pkg::KIND_LOAD: state_next = crm_pkg::ST_HOLD;
                        crm_pkg::KIND_FWD,
                        crm_pkg::KIND_REV:  state_next = crm_pkg::ST_SCAN;
                        crm_pkg::KIND_ONE:  state_next = crm_pkg::ST_LOOK;
                        default:            state_next = crm_pkg::ST_IDLE;
                    endcase
                end
            end
            crm_pkg::ST_SCAN: begin
                if (cnt_reg == crm_pkg::CNT_LAST) begin
                    state_next = crm_pkg::ST_DRAIN;
                end
            end
            crm_pkg::ST_DRAIN: state_next = crm_pkg::ST_HOLD;
            crm_pkg::ST_LOOK:  state_next = crm_pkg::ST_HOLD;
            crm_pkg::ST_HOLD: begin
                if (out_free) begin
                    state_next = crm_pkg::ST_IDLE;
                end
            end
            default: state_next = crm_pkg::ST_IDLE;
        endcase
    end

    // state decodes
    always_comb begin
        s_tready = 1'b0;
        scan_en  = 1'b0;
        look_en  = 1'b0;
        out_load = 1'b0;
        unique case (state_reg)
            crm_pkg::ST_IDLE:  s_tready = 1'b1;
            crm_pkg::ST_SCAN:  scan_en  = 1'b1;
            crm_pkg::ST_DRAIN: ;
            crm_pkg::ST_LOOK:  look_en  = 1'b1;
            crm_pkg::ST_HOLD:  out_load = out_free;
            default: ;
        endcase
    end

    // table ports: loads write at accept, scans and lookups read
    always_comb begin
        fwd_req.wr_en   = accept && (in_kind == crm_pkg::KIND_LOAD) && load_ok;
        fwd_req.wr_addr = in_from[crm_pkg::IDX_W-1:0];
        fwd_req.wr_data = in_to[crm_pkg::ENT_W-1:0];
        fwd_req.rd_en   = scan_en && (kind_reg == crm_pkg::KIND_FWD);
        fwd_req.rd_addr = cnt_reg[crm_pkg::IDX_W-1:0];

        rev_req.wr_en   = fwd_req.wr_en;
        rev_req.wr_addr = in_to[crm_pkg::IDX_W-1:0];
        rev_req.wr_data = in_from[crm_pkg::ENT_W-1:0];
        rev_req.rd_en   = (scan_en && (kind_reg == crm_pkg::KIND_REV))
                          || (accept && (in_kind == crm_pkg::KIND_ONE));
        rev_req.rd_addr = scan_en ? cnt_reg[crm_pkg::IDX_W-1:0]
                                  : in_single[crm_pkg::IDX_W-1:0];
    end

    crm_table u_fwd (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (fwd_req),
        .rd_data (fwd_data)
    );

    crm_table u_rev (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (rev_req),
        .rd_data (rev_data)
    );

    // scatter stage: one mapped bit per cycle
    assign tab_val   = (kind_reg == crm_pkg::KIND_REV) ? rev_data : fwd_data;
    assign bit_pos   = pass_reg ? pidx_reg : tab_val;
    assign bit_dec   = crm_pkg::MASK_W'(1) << bit_pos;
    assign pend_next = scan_en && mask_sr_reg[0];

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= crm_pkg::ST_IDLE;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            kind_reg     <= in_kind;
            mask_sr_reg  <= in_mask;
            cnt_reg      <= '0;
            raw_reg      <= in_single;
            in_range_reg <= single_ok;
            res_mask_reg <= '0;
            res_cpu_reg  <= '0;
            res_err_reg  <= (in_kind == crm_pkg::KIND_LOAD) && !load_ok;
        end else begin
            if (scan_en) begin
                mask_sr_reg <= mask_sr_reg >> 1;
                cnt_reg     <= cnt_reg + 1'b1;
            end
            if (pend_reg) begin
                res_mask_reg <= res_mask_reg | bit_dec;
            end
            if (look_en) begin
                res_cpu_reg <= in_range_reg ? crm_pkg::SCPU_W'(rev_data) : raw_reg;
            end
        end
        // bit index travels alongside the table read
        pass_reg <= !scan_in_range;
        pidx_reg <= cnt_reg;
    end

    // output register
    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_mask_reg <= res_mask_reg;
            m_cpu_reg  <= res_cpu_reg;
            m_err_reg  <= res_err_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'b0, m_err_reg, m_cpu_reg, m_mask_reg};

endmodule

// ===== hdl/crm_table.sv =====
module crm_table (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  crm_pkg::tbl_req_t           req,
    output logic [crm_pkg::ENT_W-1:0]   rd_data
);

    logic [crm_pkg::ENT_W-1:0] tbl_mem [crm_pkg::NCPU];
    logic [crm_pkg::NCPU-1:0]  vld_reg;
    logic [crm_pkg::NCPU-1:0]  vld_next;
    logic [crm_pkg::ENT_W-1:0] q_reg;
    logic                      q_vld_reg;
    logic [crm_pkg::IDX_W-1:0] q_addr_reg;

    // entry becomes valid on its first write
    always_comb begin
        vld_next = vld_reg;
        if (req.wr_en) begin
            vld_next[req.wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    // memory write and registered read
    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            tbl_mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en) begin
            q_reg      <= tbl_mem[req.rd_addr];
            q_vld_reg  <= vld_reg[req.rd_addr];
            q_addr_reg <= req.rd_addr;
        end
    end

    // unwritten entries read as identity
    assign rd_data = q_vld_reg ? q_reg : crm_pkg::ENT_W'(q_addr_reg);

endmodule
